// ===== rtl/assert_macros.svh =====
// assertion macros shared by the curve lookup rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/plcl_pkg.sv =====
// shared constants, codes and types of the piecewise-linear curve lookup
// no dependencies
`default_nettype none

package plcl_pkg;

    // table size and derived widths
    localparam int MAX_POINTS = 16;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // fixed field widths
    localparam int VAL_W      = 16;
    localparam int IDX_W      = 4;
    localparam int NUM_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // serial arithmetic sizing: magnitudes, product, two bits per step
    localparam int MAG_W      = 16;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int MUL_STEPS  = MAG_W / 2;
    localparam int DIV_STEPS  = PROD_W / 2;
    localparam int MUL_CW     = $clog2(MUL_STEPS);
    localparam int DIV_CW     = $clog2(DIV_STEPS);

    localparam logic [NUM_W-1:0] NUM_POINTS_RST = NUM_W'(16);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = CFG_IDX_W'(1);

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } t_mul_out;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quo;
        logic [MAG_W-1:0]  rem;
    } t_div_out;

endpackage

`default_nettype wire

// ===== rtl/plcl_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module plcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/plcl_mul.sv =====
// serial unsigned multiplier, two multiplier bits retired per cycle
// depends on plcl_pkg
`default_nettype none

module plcl_mul import plcl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_a,
    input  logic [MAG_W-1:0] i_b,
    output t_mul_out         o_res
);

    logic              r_run;
    logic              r_done;
    logic [MUL_CW-1:0] r_cnt;
    logic [MAG_W-1:0]  r_a;
    logic [PROD_W-1:0] r_prod;
    logic [MAG_W+1:0]  w_sum;

    // upper half plus a times the low two multiplier bits
    assign w_sum = {2'b00, r_prod[PROD_W-1:MAG_W]}
                 + ({2'b00, r_a} & {(MAG_W+2){r_prod[0]}})
                 + ({1'b0, r_a, 1'b0} & {(MAG_W+2){r_prod[1]}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + MUL_CW'(1);
                if (r_cnt == MUL_CW'(MUL_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_prod <= {{MAG_W{1'b0}}, i_b};
        end else if (r_run) begin
            r_prod <= {w_sum, r_prod[MAG_W-1:2]};
        end
    end

    assign o_res.done = r_done;
    assign o_res.prod = r_prod;

endmodule

`default_nettype wire

// ===== rtl/plcl_div.sv =====
// serial restoring divider, two quotient bits per cycle
// depends on plcl_pkg
`default_nettype none

module plcl_div import plcl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_num,
    input  logic [MAG_W-1:0]  i_den,
    output t_div_out          o_res
);

    localparam int RQ_W = MAG_W + PROD_W;

    logic              r_run;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [MAG_W-1:0]  r_den;
    logic [RQ_W-1:0]   r_rq;

    // remainder in the top bits, dividend shifting out into quotient below
    function automatic logic [RQ_W-1:0] div_step(input logic [RQ_W-1:0] v,
                                                 input logic [MAG_W-1:0] d);
        logic [MAG_W:0] t;
        logic [MAG_W:0] s;
        t = {v[RQ_W-1:PROD_W], v[PROD_W-1]};
        s = t - {1'b0, d};
        if (!s[MAG_W]) begin
            div_step = {s[MAG_W-1:0], v[PROD_W-2:0], 1'b1};
        end else begin
            div_step = {t[MAG_W-1:0], v[PROD_W-2:0], 1'b0};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + DIV_CW'(1);
                if (r_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rq  <= {{MAG_W{1'b0}}, i_num};
        end else if (r_run) begin
            r_rq <= div_step(div_step(r_rq, r_den), r_den);
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_rq[PROD_W-1:0];
    assign o_res.rem  = r_rq[RQ_W-1:PROD_W];

endmodule

`default_nettype wire

// ===== rtl/piecewise_linear_curve_lookup.sv =====
// top level of the piecewise-linear curve lookup: table ram, segment scan, control
// depends on plcl_pkg, plcl_ram, plcl_mul, plcl_div and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

// Piecewise-linear curve lookup. A word is accepted when start is high and busy
// is low. A write word (op 0) stores one (x,y) breakpoint in the same edge and
// gives no result; the block stays free. An evaluate word (op 1) raises busy
// while the block walks the breakpoint table through the single read port of the
// table ram, one breakpoint per cycle, until the query x stops passing them.
// Clamped queries (before the first or past the last breakpoint), exact hits on
// a breakpoint and degenerate segments finish right there. A query that lands
// inside a segment then runs a serial multiply of dy by (x-x1), 2 bits per
// cycle, and a serial restoring divide by dx, 2 quotient bits per cycle, to
// give the interpolated result. The result appears on o_y_result, o_segment
// and the clamp flags for exactly one cycle with o_valid high; the receiver
// cannot stall it, so capture it in that cycle. busy drops in the same cycle,
// so the next word may be started while a result is shown. The table has no
// reset: evaluate only over entries already written. Configuration writes are
// taken at any edge with i_cfg_we high but should only be issued while idle.
module piecewise_linear_curve_lookup import plcl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // command channel
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_op,
    input  logic [IDX_W-1:0]        i_point_index,
    input  logic signed [VAL_W-1:0] i_x_value,
    input  logic signed [VAL_W-1:0] i_y_value,
    // result strobe and payload
    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_y_result,
    output logic [CNT_W-1:0]        o_segment,
    output logic                    o_clamped_low,
    output logic                    o_clamped_high,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_MUL  = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

    // configuration registers
    logic [NUM_W-1:0] r_num_points;
    logic             r_descending;

    // control
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_seg;
    logic [CNT_W-1:0] r_n;
    logic             r_desc;
    logic             r_valid;

    // per-query payload
    logic signed [VAL_W-1:0] r_x;
    logic [2*VAL_W-1:0]      r_prev;
    logic signed [VAL_W-1:0] r_y1;
    logic [MAG_W-1:0]        r_dxm;
    logic                    r_neg;

    // result registers
    logic signed [VAL_W-1:0] r_out_y;
    logic [CNT_W-1:0]        r_out_seg;
    logic                    r_out_lo;
    logic                    r_out_hi;

    // handshake
    logic w_accept;
    logic w_wr;
    logic w_eval;

    // table ram
    logic [PT_AW-1:0]   w_raddr;
    logic [2*VAL_W-1:0] w_rdata;

    // scan datapath
    logic [CNT_W-1:0]        w_n;
    logic [CNT_W-1:0]        w_seg_next;
    logic signed [VAL_W-1:0] w_px;
    logic signed [VAL_W-1:0] w_py;
    logic signed [VAL_W-1:0] w_x1;
    logic signed [VAL_W-1:0] w_y1;
    logic                    w_passed;
    logic signed [VAL_W:0]   w_dy;
    logic signed [VAL_W:0]   w_dxq;
    logic signed [VAL_W:0]   w_dx;
    logic [MAG_W-1:0]        w_dym;
    logic [MAG_W-1:0]        w_dxqm;
    logic [MAG_W-1:0]        w_dxm;

    // finishing
    logic                    w_fin;
    logic signed [VAL_W-1:0] w_fin_y;
    logic [CNT_W-1:0]        w_fin_seg;
    logic                    w_mul_start;
    logic                    w_c;
    logic [VAL_W-1:0]        w_mag;
    logic [VAL_W-1:0]        w_interp;

    t_mul_out w_mul;
    t_div_out w_div;

    // magnitude of a 17-bit difference, which never exceeds 16 bits
    function automatic logic [MAG_W-1:0] mag17(input logic signed [VAL_W:0] v);
        logic [VAL_W:0] t;
        t = v[VAL_W] ? (VAL_W+1)'(-v) : v;
        mag17 = t[MAG_W-1:0];
    endfunction

    assign w_accept = start && !busy;
    assign w_wr     = w_accept && (i_op == OP_WRITE)
                   && (32'(i_point_index) < MAX_POINTS);
    assign w_eval   = w_accept && (i_op == OP_EVAL);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= NUM_POINTS_RST;
            r_descending <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUM_POINTS: r_num_points <= i_cfg_data[NUM_W-1:0];
                CFG_DESCENDING: r_descending <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective point count: zero means one, saturate at table size
    always_comb begin
        if (r_num_points == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_num_points) > MAX_POINTS) begin
            w_n = CNT_W'(MAX_POINTS);
        end else begin
            w_n = CNT_W'(r_num_points);
        end
    end

    // breakpoint table, x in the upper half, y in the lower
    assign w_seg_next = r_seg + CNT_W'(1);
    assign w_raddr    = (r_state == S_SCAN) ? PT_AW'(w_seg_next) : '0;

    plcl_ram #(
        .WIDTH (2 * VAL_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (PT_AW'(i_point_index)),
        .i_wdata ({i_x_value, i_y_value}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // entry r_seg arrives while scanning, entry r_seg-1 sits in r_prev
    assign w_px     = w_rdata[2*VAL_W-1:VAL_W];
    assign w_py     = w_rdata[VAL_W-1:0];
    assign w_x1     = r_prev[2*VAL_W-1:VAL_W];
    assign w_y1     = r_prev[VAL_W-1:0];
    assign w_passed = r_desc ? (r_x <= w_px) : (r_x >= w_px);

    assign w_dy   = (VAL_W+1)'(w_py) - (VAL_W+1)'(w_y1);
    assign w_dxq  = (VAL_W+1)'(r_x)  - (VAL_W+1)'(w_x1);
    assign w_dx   = (VAL_W+1)'(w_px) - (VAL_W+1)'(w_x1);
    assign w_dym  = mag17(w_dy);
    assign w_dxqm = mag17(w_dxq);
    assign w_dxm  = mag17(w_dx);

    plcl_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_dym),
        .i_b     (w_dxqm),
        .o_res   (w_mul)
    );

    plcl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul.done),
        .i_num   (w_mul.prod),
        .i_den   (r_dxm),
        .o_res   (w_div)
    );

    // rounding term (2r)/dx is one when twice the remainder reaches dx
    assign w_c      = ({w_div.rem, 1'b0} >= {1'b0, r_dxm});
    assign w_mag    = w_div.quo[VAL_W-1:0] + VAL_W'(w_c);
    assign w_interp = (r_neg ? (-w_mag) : w_mag) + r_y1;

    // next state and finishing decisions
    always_comb begin
        n_state     = r_state;
        w_fin       = 1'b0;
        w_fin_y     = w_py;
        w_fin_seg   = r_seg;
        w_mul_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_eval) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_passed) begin
                    if (w_seg_next == r_n) begin
                        // past the last breakpoint
                        w_fin     = 1'b1;
                        w_fin_seg = w_seg_next;
                        n_state   = S_IDLE;
                    end
                end else if (r_seg == '0) begin
                    // before the first breakpoint
                    w_fin   = 1'b1;
                    n_state = S_IDLE;
                end else if (r_x == w_x1) begin
                    w_fin   = 1'b1;
                    w_fin_y = w_y1;
                    n_state = S_IDLE;
                end else if (r_x == w_px) begin
                    w_fin   = 1'b1;
                    n_state = S_IDLE;
                end else if (w_x1 == w_px) begin
                    // degenerate segment
                    w_fin   = 1'b1;
                    w_fin_y = w_y1;
                    n_state = S_IDLE;
                end else begin
                    w_mul_start = 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                if (w_mul.done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    w_fin   = 1'b1;
                    w_fin_y = w_interp;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seg   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_fin;
            if (w_eval) begin
                r_seg <= '0;
            end else if (r_state == S_SCAN && w_passed && w_seg_next != r_n) begin
                r_seg <= w_seg_next;
            end
        end
    end

    // query and segment payload
    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_x    <= i_x_value;
            r_n    <= w_n;
            r_desc <= r_descending;
        end
        if (r_state == S_SCAN) begin
            r_prev <= w_rdata;
        end
        if (w_mul_start) begin
            r_y1  <= w_y1;
            r_dxm <= w_dxm;
            r_neg <= w_dy[VAL_W] ^ w_dxq[VAL_W] ^ w_dx[VAL_W];
        end
        if (w_fin) begin
            r_out_y   <= w_fin_y;
            r_out_seg <= w_fin_seg;
            r_out_lo  <= (w_fin_seg == '0);
            r_out_hi  <= (w_fin_seg == r_n);
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_y_result     = r_out_y;
    assign o_segment      = r_out_seg;
    assign o_clamped_low  = r_out_lo;
    assign o_clamped_high = r_out_hi;

    // checks
    `ASSERT_NEXT(a_eval_goes_busy, i_clk, i_rst_n, w_eval, busy,
        "evaluate word did not raise busy")
    `ASSERT_IMPL(a_valid_after_work, i_clk, i_rst_n, o_valid,
        $past(r_state) != S_IDLE, "result strobe without a preceding evaluation")
    `ASSERT_IMPL(a_mul_done_in_mul, i_clk, i_rst_n, w_mul.done, r_state == S_MUL,
        "multiplier finished outside the multiply phase")
    `ASSERT_IMPL(a_div_done_in_div, i_clk, i_rst_n, w_div.done, r_state == S_DIV,
        "divider finished outside the divide phase")
    `ASSERT_IMPL(a_seg_in_range, i_clk, i_rst_n, o_valid, o_segment <= r_n,
        "segment count beyond the point count")

endmodule

`default_nettype wire

// ===== tb/curve_lookup_checker.sv =====
// checker for the curve lookup: keeps its own breakpoint table and config copy,
// predicts every lookup word and compares it with the result strobe
// depends on plcl_pkg for widths and codes
module curve_lookup_checker import plcl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic                    i_op,
    input  logic [IDX_W-1:0]        i_point_index,
    input  logic signed [VAL_W-1:0] i_x_value,
    input  logic signed [VAL_W-1:0] i_y_value,
    input  logic                    i_valid,
    input  logic signed [VAL_W-1:0] i_y_result,
    input  logic [CNT_W-1:0]        i_segment,
    input  logic                    i_clamped_low,
    input  logic                    i_clamped_high,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_low_count,
    output int                      o_high_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [VAL_W-1:0] y;
        logic [CNT_W-1:0]        seg;
        logic                    low;
        logic                    high;
    } t_lookup_word;

    t_lookup_word            lookups_due [$];
    logic signed [VAL_W-1:0] point_x [MAX_POINTS];
    logic signed [VAL_W-1:0] point_y [MAX_POINTS];
    logic [NUM_W-1:0]        points_reg;
    logic                    descending_reg;

    // scan the table, then clamp or interpolate at full width
    function automatic t_lookup_word interpolate_curve(logic signed [VAL_W-1:0] qx);
        t_lookup_word w;
        int           n;
        int           seg;
        bit           stop;
        longint       lx, x1, x2, y1, y2, dx, prod, quo, remd, y;
        n = (points_reg == 0) ? 1 : (points_reg > MAX_POINTS) ? MAX_POINTS : int'(points_reg);
        seg = 0;
        stop = 1'b0;
        while (seg < n && !stop) begin
            if (descending_reg ? (qx <= point_x[seg]) : (qx >= point_x[seg]))
                seg++;
            else
                stop = 1'b1;
        end
        lx = qx;
        if (seg == 0) begin
            y = point_y[0];
        end else if (seg == n) begin
            y = point_y[n-1];
        end else begin
            x1 = point_x[seg-1];
            x2 = point_x[seg];
            y1 = point_y[seg-1];
            y2 = point_y[seg];
            if (lx == x1) begin
                y = y1;
            end else if (lx == x2) begin
                y = y2;
            end else if (x1 == x2) begin
                y = y1;
            end else begin
                dx   = x2 - x1;
                prod = (y2 - y1) * (lx - x1);
                quo  = prod / dx;
                remd = prod % dx;
                y    = quo + y1 + (2 * remd) / dx;
            end
        end
        w.y    = y[VAL_W-1:0];
        w.seg  = CNT_W'(seg);
        w.low  = (seg == 0);
        w.high = (seg == n);
        return w;
    endfunction

    task automatic report_mismatch(string msg);
        if (o_fail_count < 40)
            $display("mismatch on lookup %0d: %s", o_checked, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_lookup_word want;
        if (!i_rst_n) begin
            lookups_due.delete();
            points_reg     = NUM_POINTS_RST;
            descending_reg = 1'b0;
            foreach (point_x[k]) begin
                point_x[k] = '0;
                point_y[k] = '0;
            end
        end else begin
            if (i_valid) begin
                if (lookups_due.size() == 0) begin
                    report_mismatch("result word with no lookup outstanding");
                end else begin
                    want = lookups_due.pop_front();
                    if (i_y_result !== want.y)
                        report_mismatch($sformatf("y_result got %0d want %0d",
                                                  i_y_result, want.y));
                    if (i_segment !== want.seg)
                        report_mismatch($sformatf("segment got %0d want %0d",
                                                  i_segment, want.seg));
                    if (i_clamped_low !== want.low)
                        report_mismatch($sformatf("clamped_low got %b want %b",
                                                  i_clamped_low, want.low));
                    if (i_clamped_high !== want.high)
                        report_mismatch($sformatf("clamped_high got %b want %b",
                                                  i_clamped_high, want.high));
                    o_checked++;
                    if (want.low)
                        o_low_count++;
                    if (want.high)
                        o_high_count++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_POINTS: points_reg = i_cfg_data;
                    CFG_DESCENDING: descending_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (i_op == OP_EVAL) begin
                    lookups_due.push_back(interpolate_curve(i_x_value));
                end else begin
                    point_x[i_point_index] = i_x_value;
                    point_y[i_point_index] = i_y_value;
                end
            end
        end
        o_pending = lookups_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
// top of the curve lookup testbench: clock, reset, word and config stimulus, verdict
// depends on plcl_pkg, piecewise_linear_curve_lookup and curve_lookup_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import plcl_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 5;
    // quiet time once no lookup is outstanding, so the block is surely idle
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 1850;

    // register indexes beyond the defined ones, must have no effect
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    start          = 1'b0;
    logic                    busy;
    t_op                     i_op           = OP_WRITE;
    logic [IDX_W-1:0]        i_point_index  = '0;
    logic signed [VAL_W-1:0] i_x_value      = '0;
    logic signed [VAL_W-1:0] i_y_value      = '0;
    logic                    o_valid;
    logic signed [VAL_W-1:0] o_y_result;
    logic [CNT_W-1:0]        o_segment;
    logic                    o_clamped_low;
    logic                    o_clamped_high;
    logic                    i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data     = '0;

    int fail_count;
    int pending;
    int checked;
    int low_count;
    int high_count;
    int cycle_count = 0;
    int word_count  = 0;
    int write_count = 0;
    int phase_count = 0;

    // stimulus-side copy of the table x values, used to aim queries and rewrites
    logic signed [VAL_W-1:0] curve_x [MAX_POINTS] = '{default: '0};
    // breakpoint x values of the table being built for the next phase
    int                      staged_x [MAX_POINTS];

    always #CLK_HALF i_clk = ~i_clk;

    piecewise_linear_curve_lookup i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_point_index  (i_point_index),
        .i_x_value      (i_x_value),
        .i_y_value      (i_y_value),
        .o_valid        (o_valid),
        .o_y_result     (o_y_result),
        .o_segment      (o_segment),
        .o_clamped_low  (o_clamped_low),
        .o_clamped_high (o_clamped_high),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    curve_lookup_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_op           (i_op),
        .i_point_index  (i_point_index),
        .i_x_value      (i_x_value),
        .i_y_value      (i_y_value),
        .i_valid        (o_valid),
        .i_y_result     (o_y_result),
        .i_segment      (o_segment),
        .i_clamped_low  (o_clamped_low),
        .i_clamped_high (o_clamped_high),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_low_count    (low_count),
        .o_high_count   (high_count)
    );

    // hang guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d lookups outstanding",
                     cycle_count, pending);
            $display("testbench failed");
            $finish;
        end
    end

    // present one word after an optional idle gap; called and returns at a falling edge.
    // start is left high so a back-to-back word never drops it in between
    task automatic send_word(t_op op, int idx, int xv, int yv, int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op          = op;
        i_point_index = IDX_W'(idx);
        i_x_value     = VAL_W'(xv);
        i_y_value     = VAL_W'(yv);
        start         = 1'b1;
        // busy is stable between edges, so low here means the next edge takes it
        while (busy)
            @(negedge i_clk);
        @(negedge i_clk);
        if (op == OP_WRITE) begin
            curve_x[idx[IDX_W-1:0]] = VAL_W'(xv);
            write_count++;
        end
        word_count++;
    endtask

    // config writes are issued only with the block idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = CFG_DATA_W'(data);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // stop sending, wait for every lookup to come back, then let the block go quiet
    task automatic settle();
        start = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // one random phase: new config, a freshly loaded table, then lookups with
    // the odd table rewrite mixed in
    task automatic random_phase();
        int cfg_n, n, lo, hi, k, j, t, v, qx, evals, gap_max;
        bit desc, sorted, small_y, backward;
        settle();
        case ($urandom_range(0, 9))
            0:       cfg_n = 0;
            1:       cfg_n = 1;
            2:       cfg_n = $urandom_range(17, 31);
            3, 4:    cfg_n = 16;
            default: cfg_n = $urandom_range(2, 15);
        endcase
        // first random phase pins the all-ones count, which saturates
        if (phase_count == 0)
            cfg_n = 31;
        desc = $urandom_range(0, 1);
        write_reg(CFG_NUM_POINTS, cfg_n);
        // upper data bits of the direction register are don't-care
        write_reg(CFG_DESCENDING, int'({4'($urandom_range(0, 15)), desc}));
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom_range(0, 31));
        n = (cfg_n == 0) ? 1 : (cfg_n > MAX_POINTS) ? MAX_POINTS : cfg_n;
        phase_count++;

        // some phases run with no gaps at all
        gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 7;
        sorted   = ($urandom_range(0, 4) != 0);
        small_y  = $urandom_range(0, 1);
        backward = $urandom_range(0, 1);

        // x spread: full range, a crowded one with repeats, or a moderate one
        case ($urandom_range(0, 2))
            0: begin
                lo = -32768;
                hi = 32767;
            end
            1: begin
                lo = int'($urandom_range(0, 65535)) - 32768;
                hi = lo + int'($urandom_range(0, 40));
            end
            default: begin
                lo = int'($urandom_range(0, 65535)) - 32768;
                hi = lo + int'($urandom_range(0, 2000));
            end
        endcase
        if (hi > 32767)
            hi = 32767;
        for (k = 0; k < n; k++)
            staged_x[k] = lo + int'($urandom_range(0, hi - lo));
        if ($urandom_range(0, 4) == 0) begin
            staged_x[0]   = -32768;
            staged_x[n-1] = 32767;
        end

        // well-formed tables are ordered in the configured direction
        if (sorted) begin
            for (k = 1; k < n; k++) begin
                v = staged_x[k];
                j = k;
                while (j > 0 && (desc ? staged_x[j-1] < v : staged_x[j-1] > v)) begin
                    staged_x[j] = staged_x[j-1];
                    j--;
                end
                staged_x[j] = v;
            end
        end

        // load every entry in use so the scan never reads an unwritten one
        for (j = 0; j < n; j++) begin
            k = backward ? n - 1 - j : j;
            send_word(OP_WRITE, k, staged_x[k],
                      small_y ? int'($urandom_range(0, 200)) - 100 : int'($urandom),
                      $urandom_range(0, gap_max));
        end

        evals = $urandom_range(8, 40);
        for (j = 0; j < evals; j++) begin
            k = $urandom_range(0, n - 1);
            if ($urandom_range(0, 9) == 0) begin
                // rewrite: mostly a new y on a kept x, sometimes a wild point
                t = $urandom_range(0, MAX_POINTS - 1);
                if ($urandom_range(0, 2) != 0)
                    send_word(OP_WRITE, t, curve_x[t], int'($urandom),
                              $urandom_range(0, gap_max));
                else
                    send_word(OP_WRITE, t, int'($urandom), int'($urandom),
                              $urandom_range(0, gap_max));
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: qx = curve_x[k];
                    3:       qx = curve_x[k] + 1;
                    4:       qx = curve_x[k] - 1;
                    5:       qx = $urandom_range(0, 1) ? -32768 : 32767;
                    6:       qx = int'($urandom_range(0, 65535)) - 32768;
                    default: begin
                        // somewhere between entry k and the next entry, wrapping from the last to the first
                        lo = curve_x[k];
                        hi = curve_x[(k + 1) % n];
                        if (lo > hi) begin
                            t  = lo;
                            lo = hi;
                            hi = t;
                        end
                        qx = lo + int'($urandom_range(0, hi - lo));
                    end
                endcase
                // index and y of a lookup are don't-care, keep them moving
                send_word(OP_EVAL, $urandom_range(0, MAX_POINTS - 1), qx, int'($urandom),
                          $urandom_range(0, gap_max));
            end
        end
    endtask

    initial begin
        int directed_words;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // two points spanning the whole range: widest dx and dy
        write_reg(CFG_NUM_POINTS, 2);
        write_reg(CFG_DESCENDING, 0);
        // unknown indexes with all-ones data must leave the count at 2
        write_reg(CFG_SPARE_A, 5'h1F);
        write_reg(CFG_SPARE_B, 5'h1F);
        send_word(OP_WRITE, 0, -32768, 32767, 0);
        send_word(OP_WRITE, 15, 32767, -32768, 2);
        send_word(OP_WRITE, 1, 32767, -32768, 0);
        send_word(OP_EVAL, 0, -32768, 0, 0);      // exact hit on the lower point
        send_word(OP_EVAL, 15, 0, -1, 3);         // mid-span, big negative product
        send_word(OP_EVAL, 0, 1, 0, 0);
        send_word(OP_EVAL, 0, -32767, 0, 1);
        send_word(OP_EVAL, 0, 32767, 0, 0);       // past the last point
        settle();

        // a count of zero acts as one point: both clamps reachable
        write_reg(CFG_NUM_POINTS, 0);
        send_word(OP_WRITE, 0, 0, 1234, 0);
        send_word(OP_EVAL, 0, -1, 0, 0);          // before the only point
        send_word(OP_EVAL, 0, 0, 0, 0);           // on it, so past the end
        send_word(OP_EVAL, 0, 32767, 0, 5);
        settle();

        // descending table, rounding of negative remainders
        write_reg(CFG_NUM_POINTS, 3);
        write_reg(CFG_DESCENDING, 1);
        send_word(OP_WRITE, 0, 100, -50, 0);
        send_word(OP_WRITE, 1, 0, 50, 0);
        send_word(OP_WRITE, 2, -100, -32768, 0);
        send_word(OP_EVAL, 0, 200, 0, 0);         // before the first point
        send_word(OP_EVAL, 0, 50, 0, 0);
        send_word(OP_EVAL, 0, -37, 0, 7);
        send_word(OP_EVAL, 0, 0, 0, 0);           // exact hit inside the table
        send_word(OP_EVAL, 0, -100, 0, 0);        // on the last point, so past the end
        directed_words = word_count;

        while (word_count - directed_words < RANDOM_WORDS)
            random_phase();
        settle();

        $display("sent %0d words in %0d random phases: %0d table writes, %0d lookups",
                 word_count, phase_count, write_count, word_count - write_count);
        $display("checked %0d lookups, %0d clamped low, %0d clamped high, %0d failures",
                 checked, low_count, high_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
